// ===== design/ssdf_pkg.sv =====
// Shared types, constants and the glyph helper function of the seven-segment display formatter.
`default_nettype none

package ssdf_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int ADDR_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int WP_W       = $clog2(NUM_DIGITS + 1);
    localparam int SEG_W      = 8;
    localparam int SEL_W      = 4;
    localparam int IDX_W      = 2;
    localparam int NUM_W      = 16;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 64;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DIG_LO  = 8'h30;
    localparam logic [7:0] CH_DIG_HI  = 8'h3A;
    localparam logic [7:0] CH_UPR_LO  = 8'h41;
    localparam logic [7:0] CH_UPR_HI  = 8'h47;
    localparam logic [7:0] CH_LWR_LO  = 8'h61;
    localparam logic [7:0] CH_LWR_HI  = 8'h67;
    localparam logic [7:0] CH_UPR_OFS = 8'h37;
    localparam logic [7:0] CH_LWR_OFS = 8'h57;

    localparam logic [16:0] RECIP_TEN = 17'd52429;
    localparam int          RECIP_SH  = 19;

    typedef enum logic [1:0] {
        REQ_SCAN  = 2'd0,
        REQ_NUM   = 2'd1,
        REQ_CHAR  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        REG_GLYPH_LO = 2'd0,
        REG_GLYPH_HI = 2'd1,
        REG_POINT    = 2'd2,
        REG_MINUS    = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_FULL  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NUM,
        ST_WR,
        ST_SCAN_RD,
        ST_SCAN,
        ST_MRG_RD,
        ST_MRG_WR
    } state_t;

    typedef struct packed {
        logic [63:0]      glyph_lo;
        logic [63:0]      glyph_hi;
        logic [SEG_W-1:0] point_mask;
        logic [SEG_W-1:0] minus_mask;
    } cfg_t;

    function automatic logic [SEG_W-1:0] glyph(input cfg_t cfg, input logic [3:0] idx);
        logic [63:0] tab;
        tab = idx[3] ? cfg.glyph_hi : cfg.glyph_lo;
        return tab[idx[2:0]*8 +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== design/ssdf_if.sv =====
// Handshake channel interfaces for request items and scan result items.
`default_nettype none

interface ssdf_req_if;
    import ssdf_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [NUM_W-1:0]  number_value;
    logic [7:0]        point_position;
    logic              keep_leading_zeros;
    logic [7:0]        char_code;
    logic              string_start;

    modport source (output valid, req_type, number_value, point_position,
                    keep_leading_zeros, char_code, string_start, input ready);
    modport sink (input valid, req_type, number_value, point_position,
                  keep_leading_zeros, char_code, string_start, output ready);
endinterface

interface ssdf_rsp_if;
    import ssdf_pkg::*;
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segments;
    logic [SEL_W-1:0] digit_select;
    logic [IDX_W-1:0] digit_index;

    modport source (output valid, segments, digit_select, digit_index, input ready);
    modport sink (input valid, segments, digit_select, digit_index, output ready);
endinterface

`default_nettype wire

// ===== design/ssdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ssdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [$clog2(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic [$clog2(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/ssdf_div10.sv =====
// Divide-by-ten step that yields quotient and remainder of a 16-bit value.
`default_nettype none

module ssdf_div10
    import ssdf_pkg::*;
(
    input  wire logic [NUM_W-1:0] num,
    output logic      [NUM_W-1:0] quot,
    output logic      [3:0]       rem
);

    logic [32:0]      prod;
    logic [NUM_W-1:0] times_ten;
    logic [NUM_W-1:0] diff;

    always_comb
    begin
        prod      = {17'd0, num} * {16'd0, RECIP_TEN};
        quot      = NUM_W'(prod >> RECIP_SH);
        times_ten = (quot << 3) + (quot << 1);
        diff      = num - times_ten;
        rem       = diff[3:0];
    end

endmodule

`default_nettype wire

// ===== design/ssdf_cfg.sv =====
// APB register file holding the glyph table and the point and minus patterns.
`default_nettype none

module ssdf_cfg
    import ssdf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t sel;

    assign sel    = reg_index_t'(paddr[PADDR_W-1:3]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (sel)
                REG_GLYPH_LO: cfg_next.glyph_lo   = pwdata;
                REG_GLYPH_HI: cfg_next.glyph_hi   = pwdata;
                REG_POINT:    cfg_next.point_mask = pwdata[SEG_W-1:0];
                REG_MINUS:    cfg_next.minus_mask = pwdata[SEG_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_GLYPH_LO: prdata = cfg_reg.glyph_lo;
            REG_GLYPH_HI: prdata = cfg_reg.glyph_hi;
            REG_POINT:    prdata = {56'd0, cfg_reg.point_mask};
            REG_MINUS:    prdata = {56'd0, cfg_reg.minus_mask};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_lo   <= '0;
            cfg_reg.glyph_hi   <= '0;
            cfg_reg.point_mask <= 8'h80;
            cfg_reg.minus_mask <= 8'h40;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/seven_segment_display_formatter_scan.sv =====
// Top level of the seven-segment display formatter with scan output.
`default_nettype none

// A scan tick item reads the segment store, a RAM with a registered read, and then waits
// until the output register is free; the result waits there until it is taken. A number
// item takes one divide-by-ten step of the single divider per digit, one digit written per
// cycle. A clear item sweeps the store; a character item that starts a string first sweeps
// the store. After reset the block runs a clearing pass over the store before it takes its
// first item.

module seven_segment_display_formatter_scan
    import ssdf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    ssdf_req_if.sink                req,
    ssdf_rsp_if.source              rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_DIGITS - 1);

    cfg_t cfg;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0] scan_pos_reg, scan_pos_next;
    logic [WP_W-1:0]   wp_reg, wp_next;
    logic              prev_reg, prev_next;
    phase_t            phase_reg, phase_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [7:0]        point_reg, point_next;
    logic              keep_reg, keep_next;
    logic [SEG_W-1:0]  wr_data_reg, wr_data_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SEG_W-1:0]  ram_wdata;
    logic [SEG_W-1:0]  ram_rdata;

    logic [NUM_W-1:0]  quot;
    logic [3:0]        rem;
    logic [SEG_W-1:0]  dp;

    logic              accept;
    logic [7:0]        c;
    phase_t            eff_phase;
    logic [WP_W-1:0]   eff_wp;
    logic [WP_W-1:0]   wp_inc;
    logic              eff_prev;
    logic              is_dot;
    logic [SEG_W-1:0]  pat;
    logic              is_glyph;
    logic [7:0]        hex_ofs;

    ssdf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssdf_div10 u_div10 (
        .num  (num_reg),
        .quot (quot),
        .rem  (rem)
    );

    ssdf_ram #(
        .WIDTH (SEG_W),
        .DEPTH (NUM_DIGITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign req.ready        = (state_reg == ST_IDLE);
    assign accept           = req.valid && req.ready;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.segments     = seg_reg;
    assign rsp.digit_select = sel_reg;
    assign rsp.digit_index  = idx_reg;

    assign dp = (point_reg == 8'(addr_reg)) ? cfg.point_mask : '0;

    // Character decode against the state the string would have after an optional start.
    always_comb
    begin
        c         = req.char_code;
        eff_phase = req.string_start ? PH_WRITE : phase_reg;
        eff_wp    = req.string_start ? '0 : wp_reg;
        eff_prev  = req.string_start ? 1'b0 : prev_reg;
        wp_inc    = eff_wp + WP_W'(1);
        is_dot    = (c == CH_DOT);
        hex_ofs   = '0;
        pat       = '0;
        is_glyph  = 1'b0;
        if (c >= CH_DIG_LO && c < CH_DIG_HI)
        begin
            hex_ofs  = c - CH_DIG_LO;
            pat      = glyph(cfg, hex_ofs[3:0]);
            is_glyph = 1'b1;
        end
        else if (c >= CH_UPR_LO && c < CH_UPR_HI)
        begin
            hex_ofs  = c - CH_UPR_OFS;
            pat      = glyph(cfg, hex_ofs[3:0]);
            is_glyph = 1'b1;
        end
        else if (c >= CH_LWR_LO && c < CH_LWR_HI)
        begin
            hex_ofs  = c - CH_LWR_OFS;
            pat      = glyph(cfg, hex_ofs[3:0]);
            is_glyph = 1'b1;
        end
        else if (c == CH_MINUS)
        begin
            pat      = cfg.minus_mask;
            is_glyph = 1'b1;
        end
        else if (is_dot)
        begin
            pat = cfg.point_mask;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        clr_cnt_next   = clr_cnt_reg;
        scan_pos_next  = scan_pos_reg;
        wp_next        = wp_reg;
        prev_next      = prev_reg;
        phase_next     = phase_reg;
        wr_pend_next   = wr_pend_reg;
        num_next       = num_reg;
        point_next     = point_reg;
        keep_next      = keep_reg;
        wr_data_next   = wr_data_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        seg_next       = seg_reg;
        sel_next       = sel_reg;
        idx_next       = idx_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = wr_data_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next = '0;
                    wr_pend_next = 1'b0;
                    state_next   = wr_pend_reg ? ST_WR : ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type_t'(req.req_type))
                        REQ_SCAN:
                        begin
                            addr_next     = scan_pos_reg;
                            scan_pos_next = (scan_pos_reg == LAST_ADDR) ? '0
                                            : scan_pos_reg + ADDR_W'(1);
                            state_next    = ST_SCAN_RD;
                        end
                        REQ_NUM:
                        begin
                            num_next   = req.number_value;
                            point_next = req.point_position;
                            keep_next  = req.keep_leading_zeros;
                            addr_next  = LAST_ADDR;
                            state_next = ST_NUM;
                        end
                        REQ_CHAR:
                        begin
                            if (req.string_start)
                            begin
                                wp_next    = '0;
                                prev_next  = 1'b0;
                                phase_next = PH_WRITE;
                                state_next = ST_CLEAR;
                            end
                            if (eff_phase == PH_IDLE)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (c == CH_NUL)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (eff_phase == PH_FULL)
                            begin
                                phase_next = PH_IDLE;
                                if (is_dot)
                                begin
                                    addr_next  = LAST_ADDR;
                                    state_next = ST_MRG_RD;
                                end
                            end
                            else if (eff_wp >= WP_W'(NUM_DIGITS))
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (is_dot && eff_prev && eff_wp != '0)
                            begin
                                addr_next  = ADDR_W'(eff_wp - WP_W'(1));
                                prev_next  = 1'b0;
                                state_next = ST_MRG_RD;
                            end
                            else
                            begin
                                wr_data_next = pat;
                                addr_next    = ADDR_W'(eff_wp);
                                if (!is_dot)
                                begin
                                    prev_next = is_glyph;
                                end
                                wp_next = wp_inc;
                                if (wp_inc >= WP_W'(NUM_DIGITS))
                                begin
                                    phase_next = PH_FULL;
                                end
                                if (req.string_start)
                                begin
                                    wr_pend_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_WR;
                                end
                            end
                        end
                        REQ_CLEAR:
                        begin
                            wr_pend_next = 1'b0;
                            state_next   = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_NUM:
            begin
                ram_we   = 1'b1;
                num_next = quot;
                if (!keep_reg && rem == 4'd0 && quot == '0 && addr_reg != LAST_ADDR)
                begin
                    ram_wdata = dp;
                end
                else
                begin
                    ram_wdata = glyph(cfg, rem) | dp;
                end
                if (addr_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg - ADDR_W'(1);
                end
            end
            ST_WR:
            begin
                ram_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    seg_next       = ram_rdata;
                    sel_next       = SEL_W'(1) << addr_reg;
                    idx_next       = IDX_W'(addr_reg);
                    state_next     = ST_IDLE;
                end
            end
            ST_MRG_RD:
            begin
                state_next = ST_MRG_WR;
            end
            ST_MRG_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata | cfg.point_mask;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            clr_cnt_reg   <= '0;
            scan_pos_reg  <= '0;
            wp_reg        <= '0;
            prev_reg      <= 1'b0;
            phase_reg     <= PH_IDLE;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_pos_reg  <= scan_pos_next;
            wp_reg        <= wp_next;
            prev_reg      <= prev_next;
            phase_reg     <= phase_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        point_reg   <= point_next;
        keep_reg    <= keep_next;
        wr_data_reg <= wr_data_next;
        seg_reg     <= seg_next;
        sel_reg     <= sel_next;
        idx_reg     <= idx_next;
    end

endmodule

`default_nettype wire

// ===== design/ssdf_checker.sv =====
// Port-level assertions for the display formatter and the bind that attaches them.
`default_nettype none

module ssdf_checker
    import ssdf_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic [1:0]       req_type,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic [SEG_W-1:0] rsp_segments,
    input wire logic [SEL_W-1:0] rsp_digit_select,
    input wire logic [IDX_W-1:0] rsp_digit_index
);

    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot(rsp_digit_select))
        else $error("digit select is not one-hot");

    a_sel_matches_idx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_digit_select == (SEL_W'(1) << rsp_digit_index))
        else $error("digit select does not match digit index");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segments)
                                    && $stable(rsp_digit_index))
        else $error("stalled result item changed");

    a_num_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_NUM |=> !req_ready ##1 !req_ready)
        else $error("number item finished too early");

endmodule

bind seven_segment_display_formatter_scan ssdf_checker u_ssdf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_type         (req.req_type),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_segments     (rsp.segments),
    .rsp_digit_select (rsp.digit_select),
    .rsp_digit_index  (rsp.digit_index)
);

`default_nettype wire

// ===== test/seven_segment_display_formatter_scan_tb.sv =====
`timescale 1ns / 100ps
// Testbench of the seven-segment display formatter with directed and random items.
module seven_segment_display_formatter_scan_tb;
    import ssdf_pkg::*;

    typedef struct {
        req_type_t   kind;
        logic [15:0] value;
        logic [7:0]  point;
        logic        keep;
        logic [7:0]  code;
        logic        start;
    } request_t;

    typedef struct {
        logic [SEG_W-1:0] segments;
        logic [SEL_W-1:0] select;
        logic [IDX_W-1:0] index;
    } scan_result_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ssdf_req_if req_ch ();
    ssdf_rsp_if rsp_ch ();

    seven_segment_display_formatter_scan dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    request_t     pending_requests[$];
    scan_result_t expected_scans[$];
    int           queued_count;
    int           sent_count;
    int           accepted_count;
    int           checked_count;
    int           fail_count;
    int           setting_count;
    bit           no_stall;

    cfg_t             cfg_shadow;
    logic [SEG_W-1:0] store_shadow [NUM_DIGITS];
    int               scan_pos;
    int               write_pos;
    bit               prev_glyph;
    phase_t           str_phase;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    function automatic logic [SEG_W-1:0] glyph_pattern(logic [3:0] idx);
        logic [63:0] tab;
        tab = idx[3] ? cfg_shadow.glyph_hi : cfg_shadow.glyph_lo;
        return SEG_W'(tab >> (8 * idx[2:0]));
    endfunction

    function automatic void blank_shadow_store();
        foreach (store_shadow[i])
        begin
            store_shadow[i] = '0;
        end
    endfunction

    function automatic void format_number(logic [15:0] value, logic [7:0] point, logic keep);
        int               num;
        int               d;
        logic [SEG_W-1:0] dp;
        num = value;
        for (int pos = NUM_DIGITS - 1; pos >= 0; pos--)
        begin
            d   = num % 10;
            num = num / 10;
            dp  = (point == pos) ? cfg_shadow.point_mask : '0;
            if (!keep && d == 0 && num == 0 && pos != NUM_DIGITS - 1)
            begin
                store_shadow[pos] = dp;
            end
            else
            begin
                store_shadow[pos] = glyph_pattern(4'(d)) | dp;
            end
        end
    endfunction

    function automatic void write_char(logic [7:0] c, logic start);
        logic [SEG_W-1:0] pat;
        bit               is_glyph;
        if (start)
        begin
            blank_shadow_store();
            write_pos  = 0;
            prev_glyph = 1'b0;
            str_phase  = PH_WRITE;
        end
        if (str_phase == PH_IDLE)
        begin
            return;
        end
        if (c == CH_NUL)
        begin
            str_phase = PH_IDLE;
            return;
        end
        if (str_phase == PH_FULL)
        begin
            if (c == CH_DOT)
            begin
                store_shadow[NUM_DIGITS - 1] |= cfg_shadow.point_mask;
            end
            str_phase = PH_IDLE;
            return;
        end
        if (write_pos >= NUM_DIGITS)
        begin
            str_phase = PH_IDLE;
            return;
        end
        // A point right after a glyph lights that glyph's point and takes no digit.
        if (c == CH_DOT && prev_glyph && write_pos > 0)
        begin
            store_shadow[write_pos - 1] |= cfg_shadow.point_mask;
            prev_glyph = 1'b0;
            return;
        end
        is_glyph = 1'b1;
        if (c == CH_DOT)
        begin
            pat      = cfg_shadow.point_mask;
            is_glyph = 1'b0;
        end
        else if (c >= CH_DIG_LO && c < CH_DIG_HI)
        begin
            pat = glyph_pattern(4'(c - CH_DIG_LO));
        end
        else if (c >= CH_UPR_LO && c < CH_UPR_HI)
        begin
            pat = glyph_pattern(4'(c - CH_UPR_LO + 8'd10));
        end
        else if (c >= CH_LWR_LO && c < CH_LWR_HI)
        begin
            pat = glyph_pattern(4'(c - CH_LWR_LO + 8'd10));
        end
        else if (c == CH_MINUS)
        begin
            pat = cfg_shadow.minus_mask;
        end
        else
        begin
            pat      = '0;
            is_glyph = 1'b0;
        end
        store_shadow[write_pos] = pat;
        if (c != CH_DOT)
        begin
            prev_glyph = is_glyph;
        end
        write_pos++;
        if (write_pos >= NUM_DIGITS)
        begin
            str_phase = PH_FULL;
        end
    endfunction

    function automatic void predict_request(request_t r);
        scan_result_t want;
        unique case (r.kind)
            REQ_SCAN:
            begin
                want.segments = store_shadow[scan_pos];
                want.select   = SEL_W'(1 << scan_pos);
                want.index    = IDX_W'(scan_pos);
                expected_scans.push_back(want);
                scan_pos = (scan_pos + 1) % NUM_DIGITS;
            end
            REQ_NUM:   format_number(r.value, r.point, r.keep);
            REQ_CHAR:  write_char(r.code, r.start);
            default:   blank_shadow_store();
        endcase
    endfunction

    always @(negedge clk)
    begin
        request_t r;
        if (rst_n && sent_count == accepted_count)
        begin
            if (pending_requests.size() > 0 && (no_stall || $urandom_range(99) >= 35))
            begin
                r = pending_requests.pop_front();
                req_ch.valid              <= 1'b1;
                req_ch.req_type           <= r.kind;
                req_ch.number_value       <= r.value;
                req_ch.point_position     <= r.point;
                req_ch.keep_leading_zeros <= r.keep;
                req_ch.char_code          <= r.code;
                req_ch.string_start       <= r.start;
                sent_count++;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
        rsp_ch.ready <= rst_n && (no_stall || $urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        request_t     r;
        scan_result_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                r.kind  = req_type_t'(req_ch.req_type);
                r.value = req_ch.number_value;
                r.point = req_ch.point_position;
                r.keep  = req_ch.keep_leading_zeros;
                r.code  = req_ch.char_code;
                r.start = req_ch.string_start;
                predict_request(r);
                accepted_count++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_scans.size() == 0)
                begin
                    report_mismatch("unexpected scan item, segments", rsp_ch.segments, 0);
                end
                else
                begin
                    want = expected_scans.pop_front();
                    if (rsp_ch.segments !== want.segments)
                    begin
                        report_mismatch("segments", rsp_ch.segments, want.segments);
                    end
                    if (rsp_ch.digit_select !== want.select)
                    begin
                        report_mismatch("digit_select", rsp_ch.digit_select, want.select);
                    end
                    if (rsp_ch.digit_index !== want.index)
                    begin
                        report_mismatch("digit_index", rsp_ch.digit_index, want.index);
                    end
                    checked_count++;
                end
            end
        end
    end

    function automatic request_t noisy_request(req_type_t kind);
        request_t r;
        r.kind  = kind;
        r.value = 16'($urandom);
        r.point = 8'($urandom);
        r.keep  = 1'($urandom);
        r.code  = 8'($urandom);
        r.start = 1'($urandom);
        return r;
    endfunction

    task automatic push_request(request_t r);
        pending_requests.push_back(r);
        queued_count++;
    endtask

    task automatic push_scans(int n);
        repeat (n)
        begin
            push_request(noisy_request(REQ_SCAN));
        end
    endtask

    task automatic push_number(logic [15:0] value, logic [7:0] point, logic keep);
        request_t r;
        r       = noisy_request(REQ_NUM);
        r.value = value;
        r.point = point;
        r.keep  = keep;
        push_request(r);
    endtask

    task automatic push_char(logic [7:0] c, logic start);
        request_t r;
        r       = noisy_request(REQ_CHAR);
        r.code  = c;
        r.start = start;
        push_request(r);
    endtask

    function automatic logic [7:0] string_char_pick();
        int k;
        k = $urandom_range(99);
        if (k < 20)
        begin
            return CH_DIG_LO + 8'($urandom_range(9));
        end
        if (k < 30)
        begin
            return CH_UPR_LO + 8'($urandom_range(5));
        end
        if (k < 40)
        begin
            return CH_LWR_LO + 8'($urandom_range(5));
        end
        if (k < 60)
        begin
            return CH_DOT;
        end
        if (k < 72)
        begin
            return CH_MINUS;
        end
        if (k < 78)
        begin
            return CH_NUL;
        end
        return 8'($urandom);
    endfunction

    task automatic random_traffic(int count);
        int          target;
        int          pick;
        logic [15:0] value;
        logic [7:0]  point;
        request_t    r;
        target = queued_count + count;
        while (queued_count < target)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                push_scans($urandom_range(1, 4));
            end
            else if (pick < 50)
            begin
                case ($urandom_range(9))
                    0, 1:    value = 16'($urandom_range(9));
                    2, 3, 4: value = 16'($urandom_range(999));
                    default: value = 16'($urandom);
                endcase
                point = ($urandom_range(9) < 7) ? 8'($urandom_range(NUM_DIGITS)) : 8'($urandom);
                push_number(value, point, 1'($urandom));
            end
            else if (pick < 85)
            begin
                push_char(string_char_pick(), 1'b1);
                repeat ($urandom_range(0, 6))
                begin
                    push_char(string_char_pick(), 1'b0);
                end
                if ($urandom_range(1))
                begin
                    push_char(CH_NUL, 1'b0);
                end
                if ($urandom_range(1))
                begin
                    push_scans(NUM_DIGITS);
                end
            end
            else if (pick < 93)
            begin
                r = noisy_request(REQ_CHAR);
                r.start = ($urandom_range(9) == 0);
                push_request(r);
            end
            else
            begin
                push_request(noisy_request(REQ_CLEAR));
            end
        end
    endtask

    task automatic apb_write(reg_index_t idx, logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(8 * idx);
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [63:0] lo, logic [63:0] hi, logic [7:0] pm, logic [7:0] mm);
        apb_write(REG_GLYPH_LO, lo);
        apb_write(REG_GLYPH_HI, hi);
        apb_write(REG_POINT, PDATA_W'(pm));
        apb_write(REG_MINUS, PDATA_W'(mm));
        cfg_shadow.glyph_lo   = lo;
        cfg_shadow.glyph_hi   = hi;
        cfg_shadow.point_mask = pm;
        cfg_shadow.minus_mask = mm;
        setting_count++;
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || sent_count != accepted_count ||
               expected_scans.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        clk                       = 1'b0;
        rst_n                     = 1'b0;
        psel                      = 1'b0;
        penable                   = 1'b0;
        pwrite                    = 1'b0;
        paddr                     = '0;
        pwdata                    = '0;
        req_ch.valid              = 1'b0;
        req_ch.req_type           = REQ_SCAN;
        req_ch.number_value       = '0;
        req_ch.point_position     = '0;
        req_ch.keep_leading_zeros = 1'b0;
        req_ch.char_code          = CH_NUL;
        req_ch.string_start       = 1'b0;
        rsp_ch.ready              = 1'b0;
        no_stall                  = 1'b0;
        queued_count              = 0;
        sent_count                = 0;
        accepted_count            = 0;
        checked_count             = 0;
        fail_count                = 0;
        setting_count             = 1;
        cfg_shadow.glyph_lo       = '0;
        cfg_shadow.glyph_hi       = '0;
        cfg_shadow.point_mask     = 8'h80;
        cfg_shadow.minus_mask     = 8'h40;
        blank_shadow_store();
        scan_pos   = 0;
        write_pos  = 0;
        prev_glyph = 1'b0;
        str_phase  = PH_IDLE;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        random_traffic(60);
        drain();

        set_config(64'h077D_6D66_4F5B_063F, 64'h7179_5E39_7C77_6F7F, 8'h80, 8'h40);
        push_number(16'hFFFF, 8'd0, 1'b0);
        push_scans(NUM_DIGITS);
        push_number(16'd0, 8'd3, 1'b0);
        push_scans(NUM_DIGITS);
        push_number(16'd40, 8'd1, 1'b1);
        push_scans(NUM_DIGITS);
        push_char(CH_MINUS, 1'b1);
        push_char(CH_DIG_LO + 8'd1, 1'b0);
        push_char(CH_DOT, 1'b0);
        push_char(CH_LWR_LO, 1'b0);
        push_char(CH_UPR_HI - 8'd1, 1'b0);
        push_char(CH_DOT, 1'b0);
        push_scans(NUM_DIGITS);
        push_char(CH_DOT, 1'b1);
        push_char(CH_DOT, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(CH_NUL, 1'b0);
        push_char(CH_LWR_LO + 8'd1, 1'b0);
        push_scans(NUM_DIGITS);
        push_request(noisy_request(REQ_CLEAR));
        push_scans(2);
        drain();

        set_config({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 8'($urandom));
        random_traffic(180);
        drain();

        set_config('0, '0, 8'h00, 8'h00);
        random_traffic(120);
        drain();

        no_stall = 1'b1;
        set_config('1, '1, 8'hFF, 8'hFF);
        random_traffic(180);
        drain();
        no_stall = 1'b0;

        set_config({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 8'($urandom));
        random_traffic(180);
        drain();

        $display("Accepted %0d items and checked %0d scan items under %0d register settings.",
                 accepted_count, checked_count, setting_count);
        $display("Items mixed numbers, strings with points, stray characters and clears.");
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout waiting for the block to finish its items.");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== seven_segment_display_formatter_scan.f =====
design/ssdf_pkg.sv
design/ssdf_if.sv
design/ssdf_ram.sv
design/ssdf_div10.sv
design/ssdf_cfg.sv
design/seven_segment_display_formatter_scan.sv
design/ssdf_checker.sv
test/seven_segment_display_formatter_scan_tb.sv
